@@ hw/rtl/ilt_pkg.sv @@
package ilt_pkg;

    localparam int MAX_PARAMS = 16;
    localparam int HELD_MAX   = 60;
    localparam int PARAM_CAP  = ((MAX_PARAMS - 1) < 15) ? (MAX_PARAMS - 1) : 15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;

    localparam logic [2:0] KIND_PREFIX   = 3'd0;
    localparam logic [2:0] KIND_COMMAND  = 3'd1;
    localparam logic [2:0] KIND_MIDDLE   = 3'd2;
    localparam logic [2:0] KIND_TRAILING = 3'd3;
    localparam logic [2:0] KIND_STATUS   = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BLANK     = 2'd1;
    localparam logic [1:0] STAT_NO_CMD    = 2'd2;

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_GAP,
        PH_COMMAND,
        PH_PARAMS,
        PH_TRAILING,
        PH_DONE
    } irc_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLAY_CR,
        ST_REPLAY_LF,
        ST_FEED,
        ST_EOL,
        ST_STATUS
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_IN,
        SEL_REG,
        SEL_CR,
        SEL_LF
    } feed_sel_t;

    typedef struct packed {
        logic      take_in;
        logic      feed_en;
        feed_sel_t feed_sel;
        logic      cr_dec;
        logic      lf_clr;
        logic      emit_empty;
        logic      emit_status;
        logic      clear_all;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_crlf;
        logic held_empty;
        logic cr_zero;
        logic cr_last;
        logic lf_seen;
        logic eol_held;
        logic need_empty;
    } dp_stat_t;

endpackage

@@ hw/rtl/ilt_ctrl.sv @@
module ilt_ctrl
    import ilt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        take;

    assign take = s_tvalid && stat.out_free && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (stat.in_crlf || stat.held_empty) begin
                        state_next = s_tlast ? ST_EOL : ST_IDLE;
                    end else if (!stat.cr_zero) begin
                        state_next = ST_REPLAY_CR;
                    end else begin
                        state_next = ST_REPLAY_LF;
                    end
                end
            end
            ST_REPLAY_CR: begin
                if (stat.out_free && stat.cr_last) begin
                    state_next = stat.lf_seen ? ST_REPLAY_LF : ST_FEED;
                end
            end
            ST_REPLAY_LF: begin
                if (stat.out_free) begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED: begin
                if (stat.out_free) begin
                    state_next = stat.eol_held ? ST_EOL : ST_IDLE;
                end
            end
            ST_EOL: begin
                if (stat.out_free) begin
                    state_next = stat.need_empty ? ST_STATUS : ST_IDLE;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd      = '0;
        cmd.feed_sel = SEL_IN;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = stat.out_free;
                cmd.take_in = take;
                cmd.feed_en = take && !stat.in_crlf && stat.held_empty;
            end
            ST_REPLAY_CR: begin
                cmd.feed_sel = SEL_CR;
                cmd.feed_en  = stat.out_free;
                cmd.cr_dec   = stat.out_free;
            end
            ST_REPLAY_LF: begin
                cmd.feed_sel = SEL_LF;
                cmd.feed_en  = stat.out_free;
                cmd.lf_clr   = stat.out_free;
            end
            ST_FEED: begin
                cmd.feed_sel = SEL_REG;
                cmd.feed_en  = stat.out_free;
            end
            ST_EOL: begin
                cmd.emit_empty  = stat.out_free && stat.need_empty;
                cmd.emit_status = stat.out_free && !stat.need_empty;
                cmd.clear_all   = stat.out_free && !stat.need_empty;
            end
            ST_STATUS: begin
                cmd.emit_status = stat.out_free;
                cmd.clear_all   = stat.out_free;
            end
            default: begin
                cmd.feed_sel = SEL_IN;
            end
        endcase
    end

endmodule

@@ hw/rtl/ilt_datapath.sv @@
module ilt_datapath
    import ilt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  in_byte,
    input  logic        in_eol,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    irc_phase_t phase_reg, phase_next;
    logic [5:0] cr_cnt_reg, cr_cnt_next;
    logic       lf_seen_reg, lf_seen_next;
    logic [3:0] pcount_reg, pcount_next;
    logic       inside_reg, inside_next;
    logic       pseen_reg, pseen_next;
    logic [7:0] byte_reg;
    logic       eol_reg;

    logic       valid_reg, valid_next;
    logic [2:0] kind_reg;
    logic [3:0] num_reg;
    logic       opens_reg;
    logic       has_reg;
    logic [7:0] obyte_reg;
    logic       last_reg;
    logic [1:0] status_reg;

    // one parser step
    logic [7:0] c;
    logic       ws;
    logic [3:0] cur_param;
    irc_phase_t f_phase;
    logic [3:0] f_pcount;
    logic       f_inside;
    logic       f_pseen;
    logic       f_emit;
    logic [2:0] f_kind;
    logic       f_opens;
    logic       f_has;
    logic [1:0] line_status;
    logic       out_free;
    logic       load;

    always_comb begin
        unique case (cmd.feed_sel)
            SEL_IN:  c = in_byte;
            SEL_REG: c = byte_reg;
            SEL_CR:  c = CH_CR;
            SEL_LF:  c = CH_LF;
            default: c = in_byte;
        endcase
    end

    assign ws = (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
    assign cur_param = (pcount_reg < 4'(PARAM_CAP)) ? pcount_reg : 4'(PARAM_CAP);

    always_comb begin
        f_phase  = phase_reg;
        f_pcount = pcount_reg;
        f_inside = inside_reg;
        f_pseen  = pseen_reg;
        f_emit   = 1'b0;
        f_kind   = KIND_PREFIX;
        f_opens  = 1'b0;
        f_has    = 1'b0;
        unique case (phase_reg)
            PH_START: begin
                if (!ws) begin
                    f_emit  = 1'b1;
                    f_opens = 1'b1;
                    if (c == CH_COLON) begin
                        f_phase = PH_PREFIX;
                    end else begin
                        f_phase = PH_COMMAND;
                        f_kind  = KIND_COMMAND;
                        f_has   = 1'b1;
                    end
                end
            end
            PH_PREFIX: begin
                if (ws) begin
                    f_phase = PH_GAP;
                end else begin
                    f_emit = 1'b1;
                    f_has  = 1'b1;
                end
            end
            PH_GAP: begin
                if (!ws) begin
                    f_phase = PH_COMMAND;
                    f_emit  = 1'b1;
                    f_kind  = KIND_COMMAND;
                    f_opens = 1'b1;
                    f_has   = 1'b1;
                end
            end
            PH_COMMAND: begin
                if (ws) begin
                    f_phase = (c == CH_LF) ? PH_DONE : PH_PARAMS;
                end else begin
                    f_emit = 1'b1;
                    f_kind = KIND_COMMAND;
                    f_has  = 1'b1;
                end
            end
            PH_PARAMS: begin
                f_kind = KIND_MIDDLE;
                priority if (c == CH_LF) begin
                    f_phase  = PH_DONE;
                    f_inside = 1'b0;
                end else if (ws) begin
                    if (inside_reg) begin
                        f_inside = 1'b0;
                        if (pcount_reg < 4'd15) begin
                            f_pcount = pcount_reg + 4'd1;
                        end
                    end
                end else if (inside_reg) begin
                    f_emit = 1'b1;
                    f_has  = 1'b1;
                end else if (c == CH_COLON) begin
                    f_phase = PH_TRAILING;
                    f_pseen = 1'b1;
                    f_emit  = 1'b1;
                    f_kind  = KIND_TRAILING;
                    f_opens = 1'b1;
                end else begin
                    f_inside = 1'b1;
                    f_pseen  = 1'b1;
                    f_emit   = 1'b1;
                    f_opens  = 1'b1;
                    f_has    = 1'b1;
                end
            end
            PH_TRAILING: begin
                f_kind = KIND_TRAILING;
                if (c == CH_LF) begin
                    f_phase = PH_DONE;
                end else begin
                    f_emit = 1'b1;
                    f_has  = 1'b1;
                end
            end
            default: begin
                f_phase = phase_reg;
            end
        endcase
    end

    always_comb begin
        priority if (phase_reg == PH_START) begin
            line_status = STAT_BLANK;
        end else if ((phase_reg == PH_PREFIX) || (phase_reg == PH_GAP)) begin
            line_status = STAT_NO_CMD;
        end else begin
            line_status = STAT_OK;
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign load = (cmd.feed_en && f_emit) || cmd.emit_empty || cmd.emit_status;

    // parser state update
    always_comb begin
        phase_next   = phase_reg;
        pcount_next  = pcount_reg;
        inside_next  = inside_reg;
        pseen_next   = pseen_reg;
        cr_cnt_next  = cr_cnt_reg;
        lf_seen_next = lf_seen_reg;
        if (cmd.take_in) begin
            if (in_byte == CH_LF) begin
                lf_seen_next = 1'b1;
            end else if ((in_byte == CH_CR) && !lf_seen_reg &&
                         (cr_cnt_reg < 6'(HELD_MAX))) begin
                cr_cnt_next = cr_cnt_reg + 6'd1;
            end
        end
        if (cmd.cr_dec) begin
            cr_cnt_next = cr_cnt_reg - 6'd1;
        end
        if (cmd.lf_clr) begin
            lf_seen_next = 1'b0;
        end
        if (cmd.feed_en) begin
            phase_next  = f_phase;
            pcount_next = f_pcount;
            inside_next = f_inside;
            pseen_next  = f_pseen;
        end
        if (cmd.clear_all) begin
            phase_next   = PH_START;
            pcount_next  = '0;
            inside_next  = 1'b0;
            pseen_next   = 1'b0;
            cr_cnt_next  = '0;
            lf_seen_next = 1'b0;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            pcount_reg  <= '0;
            inside_reg  <= 1'b0;
            pseen_reg   <= 1'b0;
            cr_cnt_reg  <= '0;
            lf_seen_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pcount_reg  <= pcount_next;
            inside_reg  <= inside_next;
            pseen_reg   <= pseen_next;
            cr_cnt_reg  <= cr_cnt_next;
            lf_seen_reg <= lf_seen_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            byte_reg <= in_byte;
            eol_reg  <= in_eol;
        end
        if (load) begin
            if (cmd.emit_status) begin
                kind_reg   <= KIND_STATUS;
                num_reg    <= '0;
                opens_reg  <= 1'b0;
                has_reg    <= 1'b0;
                obyte_reg  <= '0;
                last_reg   <= 1'b1;
                status_reg <= line_status;
            end else if (cmd.emit_empty) begin
                kind_reg   <= KIND_TRAILING;
                num_reg    <= '0;
                opens_reg  <= 1'b1;
                has_reg    <= 1'b0;
                obyte_reg  <= '0;
                last_reg   <= 1'b0;
                status_reg <= STAT_OK;
            end else begin
                kind_reg   <= f_kind;
                num_reg    <= ((f_kind == KIND_MIDDLE) || (f_kind == KIND_TRAILING)) ?
                              cur_param : 4'd0;
                opens_reg  <= f_opens;
                has_reg    <= f_has;
                obyte_reg  <= f_has ? c : 8'd0;
                last_reg   <= 1'b0;
                status_reg <= STAT_OK;
            end
        end
    end

    assign stat.out_free   = out_free;
    assign stat.in_crlf    = (in_byte == CH_CR) || (in_byte == CH_LF);
    assign stat.held_empty = (cr_cnt_reg == 6'd0) && !lf_seen_reg;
    assign stat.cr_zero    = (cr_cnt_reg == 6'd0);
    assign stat.cr_last    = (cr_cnt_reg == 6'd1);
    assign stat.lf_seen    = lf_seen_reg;
    assign stat.eol_held   = eol_reg;
    assign stat.need_empty = (line_status == STAT_OK) && !pseen_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, status_reg, obyte_reg, opens_reg, num_reg};
    assign m_tuser  = {has_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

@@ hw/rtl/irc_line_tokenizer.sv @@
// irc line tokenizer: one byte per request in, tagged content bytes out
// results are registered in the output register that drives the master side
// throughput: one byte per cycle while no cr/lf run is held and the master side keeps up;
//   a byte after a held run waits while its crs, then any held lf, replay one byte a cycle
// end of line adds the status result, preceded by an empty trailing when no parameter was seen
// reset: aresetn synchronous active low, clears parser state, held run and output valid
module irc_line_tokenizer
    import ilt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave side: raw message bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_line
    // master side: tagged results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] param_number, [4] opens_field, [12:5] out_byte,
                                   // [14:13] status, [15] zero
    output logic [3:0]  m_tuser,   // [2:0] field_kind, [3] has_byte
    output logic        m_tlast    // is_last
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: accepts bytes, replays held cr/lf runs, closes the line
    ilt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // parser state, held run counters and the output register
    ilt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .in_eol   (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // only the status result closes a line, and it always does
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[2:0] == KIND_STATUS)))
        else $error("is_last and status kind disagree");

    // status is nonzero only on the closing result
    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[14:13] == STAT_OK))
        else $error("status set on a non-final result");

    // a result without content carries a zero byte
    a_empty_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[3]) |-> (m_tdata[12:5] == 8'd0))
        else $error("out_byte set without has_byte");

    // after the last byte of a line the block must close it before taking more
    a_eol_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("request taken before the line was closed");
`endif

endmodule

@@ tb/sv/tb_irc_line_tokenizer.sv @@
module tb_irc_line_tokenizer
    import ilt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int RESET_CYCLES       = 8;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int DRAIN_CYCLES       = 8;      // result latency plus status and empty trailing
    localparam int BYTES_PER_ROUND    = 28;     // three rounds of random lines
    localparam int LONG_STALL_CYCLES  = 300;    // receiver hold-off in the pressure test
    localparam int MAX_TOKENS_PER_BYTE = 64;
    localparam int PARAM_COUNT_TOP    = 15;     // param counter saturates here
    localparam int MAX_REPORTS        = 100;

    typedef logic [7:0] byte_q_t[$];

    // one tagged result as the block presents it
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] pnum;
        logic       opens;
        logic       has;
        logic [7:0] data;
        logic       last;
        logic [1:0] stat;
    } token_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    irc_line_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    int cycle_count = 0;
    int mismatch_count = 0;

    // idle percentages for each side, changed between rounds
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off: the test bumps hold_asked, the receiver grants it
    int hold_asked = 0;
    int hold_granted = 0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // predictor: a private copy of the line parser
    // ------------------------------------------------------------------
    token_rec_t  expected_tokens[$];
    irc_phase_t  line_phase;
    int          held_crs;          // crs of the held run before its first lf
    logic        held_lf;           // the held run contains an lf
    int          param_idx;
    logic        in_token;          // inside a middle parameter
    logic        saw_param;
    int          tokens_this_byte;

    function automatic void clear_parser();
        line_phase = PH_START;
        held_crs   = 0;
        held_lf    = 1'b0;
        param_idx  = 0;
        in_token   = 1'b0;
        saw_param  = 1'b0;
    endfunction

    function automatic void push_token(logic [2:0] kind, logic [3:0] pnum, logic opens,
                                       logic has, logic [7:0] b, logic last, logic [1:0] stat);
        token_rec_t rec;
        if (tokens_this_byte < MAX_TOKENS_PER_BYTE) begin
            rec = '{kind, pnum, opens, has, b, last, stat};
            expected_tokens = {expected_tokens, rec};
            tokens_this_byte++;
        end
    endfunction

    // parameter number as reported, capped
    function automatic logic [3:0] param_slot();
        return (param_idx < PARAM_CAP) ? 4'(param_idx) : 4'(PARAM_CAP);
    endfunction

    // one byte through the parser proper (held crs and lfs already resolved)
    function automatic void advance_parser(logic [7:0] c);
        logic is_space;
        is_space = (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
        case (line_phase)
            PH_START: begin
                if (!is_space) begin
                    if (c == CH_COLON) begin
                        // prefix colon opens the field but carries no byte
                        line_phase = PH_PREFIX;
                        push_token(KIND_PREFIX, 4'd0, 1'b1, 1'b0, 8'h00, 1'b0, STAT_OK);
                    end else begin
                        line_phase = PH_COMMAND;
                        push_token(KIND_COMMAND, 4'd0, 1'b1, 1'b1, c, 1'b0, STAT_OK);
                    end
                end
            end
            PH_PREFIX: begin
                if (is_space)
                    line_phase = PH_GAP;
                else
                    push_token(KIND_PREFIX, 4'd0, 1'b0, 1'b1, c, 1'b0, STAT_OK);
            end
            PH_GAP: begin
                if (!is_space) begin
                    line_phase = PH_COMMAND;
                    push_token(KIND_COMMAND, 4'd0, 1'b1, 1'b1, c, 1'b0, STAT_OK);
                end
            end
            PH_COMMAND: begin
                if (is_space)
                    line_phase = (c == CH_LF) ? PH_DONE : PH_PARAMS;
                else
                    push_token(KIND_COMMAND, 4'd0, 1'b0, 1'b1, c, 1'b0, STAT_OK);
            end
            PH_PARAMS: begin
                if (c == CH_LF) begin
                    // lf after the command closes the line
                    line_phase = PH_DONE;
                    in_token   = 1'b0;
                end else if (is_space) begin
                    if (in_token) begin
                        in_token = 1'b0;
                        if (param_idx < PARAM_COUNT_TOP)
                            param_idx++;
                    end
                end else if (in_token) begin
                    push_token(KIND_MIDDLE, param_slot(), 1'b0, 1'b1, c, 1'b0, STAT_OK);
                end else if (c == CH_COLON) begin
                    line_phase = PH_TRAILING;
                    saw_param  = 1'b1;
                    push_token(KIND_TRAILING, param_slot(), 1'b1, 1'b0, 8'h00, 1'b0, STAT_OK);
                end else begin
                    in_token  = 1'b1;
                    saw_param = 1'b1;
                    push_token(KIND_MIDDLE, param_slot(), 1'b1, 1'b1, c, 1'b0, STAT_OK);
                end
            end
            PH_TRAILING: begin
                if (c == CH_LF)
                    line_phase = PH_DONE;
                else
                    push_token(KIND_TRAILING, param_slot(), 1'b0, 1'b1, c, 1'b0, STAT_OK);
            end
            default: ;  // done: the rest of the line is ignored
        endcase
    endfunction

    // expected results of one accepted request
    function automatic void tokenize_byte(logic [7:0] b, logic eol);
        logic [1:0] stat;
        tokens_this_byte = 0;
        if (b == CH_LF) begin
            held_lf = 1'b1;
        end else if (b == CH_CR) begin
            // only crs before the first lf count, saturating
            if (!held_lf && held_crs < HELD_MAX)
                held_crs++;
        end else begin
            // replay the held run ahead of this byte
            for (int i = 0; i < held_crs; i++)
                advance_parser(CH_CR);
            if (held_lf)
                advance_parser(CH_LF);
            held_crs = 0;
            held_lf  = 1'b0;
            advance_parser(b);
        end
        if (eol) begin
            // a held run at end of line is dropped
            if (line_phase == PH_START) begin
                stat = STAT_BLANK;
            end else if (line_phase == PH_PREFIX || line_phase == PH_GAP) begin
                stat = STAT_NO_CMD;
            end else begin
                stat = STAT_OK;
                if (!saw_param)
                    push_token(KIND_TRAILING, 4'd0, 1'b1, 1'b0, 8'h00, 1'b0, STAT_OK);
            end
            push_token(KIND_STATUS, 4'd0, 1'b0, 1'b0, 8'h00, 1'b1, stat);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver and line builders
    // ------------------------------------------------------------------

    // s_tvalid is lowered only while idling or draining, never right after a request
    task automatic send_byte(logic [7:0] b, logic eol);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tokenize_byte(b, eol);
    endtask

    task automatic send_text(string s, bit eol_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eol_at_end && (i == s.len() - 1));
    endtask

    task automatic send_line(byte_q_t line);
        for (int i = 0; i < line.size(); i++)
            send_byte(line[i], i == line.size() - 1);
    endtask

    // stop offering, let every expected result arrive, then settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // token bytes: anything but whitespace and colon
    function automatic void append_token(ref byte_q_t line, input int len);
        logic [7:0] b;
        repeat (len) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_SPACE || (b >= CH_HT && b <= CH_CR) || b == CH_COLON);
            line = {line, b};
        end
    endfunction

    function automatic void append_gap(ref byte_q_t line);
        logic [7:0] b;
        repeat ($urandom_range(1, 2)) begin
            b = ($urandom_range(0, 3) == 0) ? CH_HT : CH_SPACE;
            line = {line, b};
        end
    endfunction

    // line ending: none, crlf, bare lf or a cr run then lf
    function automatic void append_line_end(ref byte_q_t line);
        case ($urandom_range(0, 3))
            0: ;
            1: line = {line, CH_CR, CH_LF};
            2: line = {line, CH_LF};
            default: begin
                repeat ($urandom_range(2, 5)) line = {line, CH_CR};
                line = {line, CH_LF};
            end
        endcase
    endfunction

    // mostly well-formed messages, some with held runs inside, some noise
    function automatic void make_line(output byte_q_t line);
        int         pick;
        int         n_params;
        logic [7:0] b;
        line = {};
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            if ($urandom_range(0, 1)) begin
                line = {line, CH_COLON};
                append_token(line, $urandom_range(1, 5));
                append_gap(line);
            end
            append_token(line, $urandom_range(1, 6));
            // now and then enough middles to saturate the param number
            n_params = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19)
                                                   : $urandom_range(0, 3);
            repeat (n_params) begin
                append_gap(line);
                append_token(line, $urandom_range(1, 4));
            end
            if ($urandom_range(0, 1)) begin
                append_gap(line);
                line = {line, CH_COLON};
                repeat ($urandom_range(0, 6)) begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_CR || b == CH_LF);
                    line = {line, b};
                end
            end
            append_line_end(line);
        end else if (pick < 85) begin
            // held run followed by more bytes, in a middle or a trailing
            append_token(line, $urandom_range(1, 4));
            append_gap(line);
            if ($urandom_range(0, 1))
                line = {line, CH_COLON};
            append_token(line, $urandom_range(1, 3));
            repeat ($urandom_range(1, 8)) line = {line, CH_CR};
            if ($urandom_range(0, 2) == 0) begin
                line = {line, CH_LF};
                repeat ($urandom_range(0, 2)) line = {line, CH_CR};
            end
            append_token(line, $urandom_range(1, 3));
            append_line_end(line);
        end else begin
            // noise biased toward the bytes the parser cares about
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 5))
                    0: line = {line, CH_COLON};
                    1: line = {line, CH_SPACE};
                    2: line = {line, CH_CR};
                    3: line = {line, CH_LF};
                    4: line = {line, CH_HT};
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        line = {line, b};
                    end
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // line of a lone cr: blank
        send_byte(CH_CR, 1'b1);
        // whitespace only: blank
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_HT, 1'b1);
        // prefix without command
        send_text(":p", 1'b1);
        // bare command gets an empty trailing
        send_text("P", 1'b1);
        // middle, trailing with its opening colon, crlf dropped at end of line
        send_text("C a :b", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b1);
        // lf before the command is whitespace; extreme byte values as command
        send_byte(CH_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // held crs replayed into the trailing, then lf ends the line early
        send_text("X :", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text("y", 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_lines(int byte_budget);
        byte_q_t line;
        int      sent;
        sent = 0;
        while (sent < byte_budget) begin
            make_line(line);
            send_line(line);
            sent += line.size();
        end
        wait_for_results();
    endtask

    // cr run past the held counter limit, replayed into a trailing
    task automatic test_held_run_overflow();
        byte_q_t line;
        line = {};
        append_token(line, 2);
        line = {line, CH_SPACE, CH_COLON};
        append_token(line, 2);
        repeat (HELD_MAX + $urandom_range(1, 4)) line = {line, CH_CR};
        append_token(line, $urandom_range(1, 3));
        line = {line, CH_CR, CH_LF};
        send_line(line);
        wait_for_results();
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        byte_q_t line;
        @(negedge aclk);
        hold_asked++;
        @(posedge aclk);
        send_text(":srv 001 nick a b :welcome to the net", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b1);
        make_line(line);
        send_line(line);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (hold_asked != hold_granted) begin
            hold_granted = hold_asked;
            stall_left   = LONG_STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge aclk) begin
        token_rec_t got;
        token_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser[2:0];
            got.has   = m_tuser[3];
            got.pnum  = m_tdata[3:0];
            got.opens = m_tdata[4];
            got.data  = m_tdata[12:5];
            got.stat  = m_tdata[14:13];
            got.last  = m_tlast;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("result with none expected, kind %0d byte %02h",
                                          got.kind, got.data));
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind != want.kind)
                    report_mismatch($sformatf("field_kind %0d, expected %0d",
                                              got.kind, want.kind));
                if (got.pnum != want.pnum)
                    report_mismatch($sformatf("param_number %0d, expected %0d",
                                              got.pnum, want.pnum));
                if (got.opens != want.opens)
                    report_mismatch($sformatf("opens_field %0d, expected %0d",
                                              got.opens, want.opens));
                if (got.has != want.has)
                    report_mismatch($sformatf("has_byte %0d, expected %0d",
                                              got.has, want.has));
                if (got.data != want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              got.data, want.data));
                if (got.last != want.last)
                    report_mismatch($sformatf("is_last %0d, expected %0d",
                                              got.last, want.last));
                if (got.stat != want.stat)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.stat, want.stat));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_tokens.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        clear_parser();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles a little, receiver a lot
        send_idle_pct = 17;
        recv_idle_pct = 58;
        test_directed_cases();
        test_random_lines(BYTES_PER_ROUND);
        test_held_run_overflow();

        // the other way round
        send_idle_pct = 58;
        recv_idle_pct = 17;
        test_random_lines(BYTES_PER_ROUND);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(BYTES_PER_ROUND);
        test_output_backpressure();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ irc_line_tokenizer.f @@
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_ctrl.sv
hw/rtl/ilt_datapath.sv
hw/rtl/irc_line_tokenizer.sv
tb/sv/tb_irc_line_tokenizer.sv
